// ----- hdl/sglu_pkg.sv -----
package sglu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic        [DATA_WIDTH-1:0] mag_t;
  typedef logic        [PROD_WIDTH-1:0] prod_t;

  localparam prod_t BOUND_POS =
    {{(PROD_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam prod_t BOUND_NEG = BOUND_POS + prod_t'(1);
  localparam word_t MIN_VALUE = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t MINUS_ONE = {DATA_WIDTH{1'b1}};

  typedef struct packed {
    word_t operand_a;
    word_t operand_b;
  } in_t;

  typedef struct packed {
    word_t gcd_value;
    word_t lcm_value;
    logic  lcm_overflow;
  } out_t;

  typedef struct packed {
    logic load;
    logic start_euc;
    logic start_lcm;
    logic div_step;
    logic euc_update;
    logic mul;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic a_zero;
    logic b_zero;
    logic div_last;
  } status_t;

  function automatic mag_t magnitude(word_t v);
    return v[DATA_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

// ----- hdl/sglu_datapath.sv -----
module sglu_datapath import sglu_pkg::*; (
  input  logic    clk,
  input  in_t     operand_word,
  input  cmd_t    cmd,
  output status_t status,
  output out_t    result_word
);

  word_t a, b, x, y;
  logic  ovf;
  mag_t  rem, quo, dvs;
  logic  [CNT_WIDTH-1:0] cnt;
  prod_t prod;
  word_t lcm;

  logic [DATA_WIDTH:0] rem_sh, rem_sub;
  logic  fits;
  mag_t  rem_new;
  word_t r_signed;
  logic  negative;
  mag_t  lcm_mag;

  assign rem_sh   = {rem, quo[DATA_WIDTH-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign rem_new  = fits ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
  assign r_signed = x[DATA_WIDTH-1] ? word_t'(-rem) : word_t'(rem);
  assign negative = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1] ^ x[DATA_WIDTH-1];
  assign lcm_mag  = prod[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= operand_word.operand_a;
      b   <= operand_word.operand_b;
      x   <= operand_word.operand_a;
      y   <= operand_word.operand_b;
      ovf <= 1'b0;
      lcm <= '0;
    end
    if (cmd.start_euc) begin
      rem <= '0;
      quo <= magnitude(x);
      dvs <= magnitude(y);
      cnt <= '0;
    end
    if (cmd.start_lcm) begin
      rem <= '0;
      quo <= magnitude(a);
      dvs <= magnitude(x);
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_new;
      quo <= {quo[DATA_WIDTH-2:0], fits};
      cnt <= cnt + CNT_WIDTH'(1);
    end
    if (cmd.euc_update) begin
      x <= y;
      y <= r_signed;
      if (x == MIN_VALUE && y == MINUS_ONE) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.mul) begin
      prod <= {{DATA_WIDTH{1'b0}}, quo} * {{DATA_WIDTH{1'b0}}, magnitude(b)};
    end
    if (cmd.fin) begin
      lcm <= negative ? word_t'(-lcm_mag) : word_t'(lcm_mag);
      if (prod > (negative ? BOUND_NEG : BOUND_POS)) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      result_word.gcd_value    <= x;
      result_word.lcm_value    <= lcm;
      result_word.lcm_overflow <= ovf;
    end
  end

  assign status.y_zero   = (y == '0);
  assign status.a_zero   = (a == '0);
  assign status.b_zero   = (b == '0);
  assign status.div_last = (cnt == CNT_WIDTH'(DATA_WIDTH-1));

endmodule

// ----- hdl/sglu_ctrl.sv -----
module sglu_ctrl import sglu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    operand_valid,
  output logic    operand_ready,
  output logic    result_valid,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EDIV  = 3'd2;
  localparam logic [2:0] S_ESTEP = 3'd3;
  localparam logic [2:0] S_LDIV  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic out_free;

  assign out_free      = !result_valid || result_ready;
  assign operand_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (operand_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.y_zero) begin
          cmd.start_euc = 1'b1;
          state_next    = S_EDIV;
        end else if (status.a_zero || status.b_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.start_lcm = 1'b1;
          state_next    = S_LDIV;
        end
      end
      S_EDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_ESTEP;
        end
      end
      S_ESTEP: begin
        cmd.euc_update = 1'b1;
        state_next     = S_CHECK;
      end
      S_LDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/signed_gcd_lcm_unit.sv -----
// channel   handshake                      word
// operand   operand_valid / operand_ready  in_t  {operand_a, operand_b}
// result    result_valid / result_ready    out_t {gcd_value, lcm_value, lcm_overflow}
//
// One word at a time. Each Euclid step runs a check, the divider iterations and an
// update; when both operands are nonzero the lcm adds a divider pass, a multiply and
// a finish. The shared 1-bit restoring divider sets the run time.
// rst is synchronous and clears the controller and result_valid.
// A finished word waits in the output register; the next operand is taken
// meanwhile and its result is held until the output register frees.
module signed_gcd_lcm_unit import sglu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic operand_valid,
  output logic operand_ready,
  input  in_t  operand_word,
  output logic result_valid,
  input  logic result_ready,
  output out_t result_word
);

  cmd_t    cmd;
  status_t status;

  sglu_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .cmd           (cmd)
  );

  sglu_datapath u_datapath (
    .clk          (clk),
    .operand_word (operand_word),
    .cmd          (cmd),
    .status       (status),
    .result_word  (result_word)
  );

endmodule

// ----- verif/tb.sv -----
module tb;
  import sglu_pkg::*;

  localparam word_t MAX_VALUE = ~MIN_VALUE;
  localparam int    RANDOM_PER_PHASE = 87;
  localparam int    DRAIN_CYCLES = 1700;

  class gcd_lcm_board;
    out_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function logic [DATA_WIDTH-1:0] abs_of(word_t v);
      return v[DATA_WIDTH-1] ? -v : v;
    endfunction

    // truncated-remainder Euclid, then |a|/|g| * |b| with the combined sign
    function out_t gcd_lcm_of(in_t w);
      word_t            x, y, r;
      logic [31:0]      rem;
      logic [63:0]      q, mb, bound, prod;
      bit               ovf, neg;
      out_t             res;
      x   = w.operand_a;
      y   = w.operand_b;
      ovf = 1'b0;
      while (y != 0) begin
        if (x == MIN_VALUE && y == MINUS_ONE) ovf = 1'b1;
        rem = abs_of(x) % abs_of(y);
        r   = x[DATA_WIDTH-1] ? word_t'(-rem) : word_t'(rem);
        x   = y;
        y   = r;
      end
      res.gcd_value = x;
      res.lcm_value = '0;
      if (w.operand_a != 0 && w.operand_b != 0) begin
        neg   = w.operand_a[DATA_WIDTH-1] ^ w.operand_b[DATA_WIDTH-1] ^ x[DATA_WIDTH-1];
        q     = {32'b0, abs_of(w.operand_a)} / {32'b0, abs_of(x)};
        mb    = {32'b0, abs_of(w.operand_b)};
        bound = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        prod  = q * mb;
        if (q != 0 && mb > bound / q) ovf = 1'b1;
        if (neg) prod = -prod;
        res.lcm_value = prod[31:0];
      end
      res.lcm_overflow = ovf;
      return res;
    endfunction

    function void note_operand(in_t w);
      pending.push_back(gcd_lcm_of(w));
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result word: gcd %0d lcm %0d ovf %0b",
               got.gcd_value, got.lcm_value, got.lcm_overflow);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.gcd_value !== exp.gcd_value) begin
        $error("gcd_value: expected %0d, got %0d", exp.gcd_value, got.gcd_value);
        errors++;
      end
      if (got.lcm_value !== exp.lcm_value) begin
        $error("lcm_value: expected %0d, got %0d", exp.lcm_value, got.lcm_value);
        errors++;
      end
      if (got.lcm_overflow !== exp.lcm_overflow) begin
        $error("lcm_overflow: expected %0b, got %0b", exp.lcm_overflow, got.lcm_overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic operand_valid = 1'b0;
  logic operand_ready;
  in_t  operand_word = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result_word;

  int send_idle  = 0;
  int recv_stall = 0;
  int send_idle_pct[4] = '{0, 62, 0, 9};
  int recv_stall_pct[4] = '{0, 0, 62, 9};

  gcd_lcm_board board = new();

  signed_gcd_lcm_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .operand_word  (operand_word),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_word   (result_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(input word_t a, input word_t b);
    in_t w;
    w.operand_a = a;
    w.operand_b = b;
    while ($urandom_range(99) < send_idle) begin
      operand_valid <= 1'b0;
      @(posedge clk);
    end
    operand_valid <= 1'b1;
    operand_word  <= w;
    do @(posedge clk); while (!operand_ready);
    board.note_operand(w);
  endtask

  function automatic word_t fib(int n);
    word_t f0, f1, t;
    f0 = 0;
    f1 = 1;
    for (int i = 0; i < n; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  function automatic word_t pick_special();
    case ($urandom_range(6))
      0:       return 0;
      1:       return 1;
      2:       return MINUS_ONE;
      3:       return MIN_VALUE;
      4:       return MAX_VALUE;
      5:       return MIN_VALUE + 1;
      default: return word_t'(1) << $urandom_range(30);
    endcase
  endfunction

  task automatic random_pair(output word_t a, output word_t b);
    word_t g;
    int    n;
    case ($urandom_range(9))
      3, 4: begin
        g = $urandom_range(65535, 1);
        a = g * (int'($urandom_range(65535)) - 32768);
        b = g * (int'($urandom_range(65535)) - 32768);
      end
      5: begin
        n = $urandom_range(46, 2);
        a = $urandom_range(1) ? fib(n) : -fib(n);
        b = $urandom_range(1) ? fib(n - 1) : -fib(n - 1);
      end
      6: begin
        a = pick_special();
        b = $urandom;
      end
      7: begin
        a = int'($urandom_range(600)) - 300;
        b = int'($urandom_range(600)) - 300;
      end
      8: begin
        a = $urandom;
        b = pick_special();
      end
      9: begin
        a = int'($urandom_range(65535)) - 32768;
        b = int'($urandom_range(65535)) - 32768;
      end
      default: begin
        a = $urandom;
        b = $urandom;
      end
    endcase
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (!rst && result_valid && result_ready) board.check_result(result_word);
      result_ready <= ($urandom_range(99) >= recv_stall);
      @(posedge clk);
    end
  end

  initial begin
    word_t a, b;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(0, 0);
    send_word(MAX_VALUE, 0);
    send_word(MIN_VALUE, 0);
    send_word(0, MIN_VALUE);
    send_word(0, MAX_VALUE);
    send_word(0, -7);
    send_word(MIN_VALUE, MINUS_ONE);
    send_word(MINUS_ONE, MIN_VALUE);
    send_word(MIN_VALUE, MIN_VALUE);
    send_word(MIN_VALUE, 1);
    send_word(1, MIN_VALUE);
    send_word(MAX_VALUE, MAX_VALUE);
    send_word(MAX_VALUE, MIN_VALUE);
    send_word(MAX_VALUE, MAX_VALUE - 1);
    send_word(MIN_VALUE, MAX_VALUE);
    send_word(80, -12);
    send_word(-80, 12);
    send_word(12, 27);
    send_word(MINUS_ONE, MINUS_ONE);
    send_word(65536, 65537);
    send_word(-65536, 65536);
    send_word(fib(46), fib(45));
    send_word(-fib(46), fib(45));
    send_word(fib(45), -fib(46));

    for (int p = 0; p < 4; p++) begin
      send_idle  = send_idle_pct[p];
      recv_stall = recv_stall_pct[p];
      repeat (RANDOM_PER_PHASE) begin
        random_pair(a, b);
        send_word(a, b);
      end
    end
    operand_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sglu_pkg.sv
hdl/sglu_datapath.sv
hdl/sglu_ctrl.sv
hdl/signed_gcd_lcm_unit.sv
verif/tb.sv
